// ===== src/tvs_pkg.sv =====
// Package: item types, action codes, sequence ids, step codes, valve bit masks and wait lengths.
package tvs_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_BYTE  = 2'd2,
    ACT_BIT   = 2'd3
  } action_t;

  localparam logic [2:0] SEQ_CATCH       = 3'd0;
  localparam logic [2:0] SEQ_SHOOT_START = 3'd1;
  localparam logic [2:0] SEQ_SHOOT_STOP  = 3'd2;
  localparam logic [2:0] SEQ_RIGHT       = 3'd3;
  localparam logic [2:0] SEQ_LEFT        = 3'd4;
  localparam logic [2:0] SEQ_RESET       = 3'd5;

  localparam logic [2:0] STEP_IDLE   = 3'd0;
  localparam logic [2:0] STEP_FIRST  = 3'd1;
  localparam logic [2:0] STEP_WAIT_A = 3'd2;
  localparam logic [2:0] STEP_MID    = 3'd3;
  localparam logic [2:0] STEP_WAIT_B = 3'd4;
  localparam logic [2:0] STEP_LAST   = 3'd5;
  localparam logic [2:0] STEP_END    = 3'd6;

  localparam int ARM_LEFT_BIT      = 0;
  localparam int ARM_RIGHT_BIT     = 1;
  localparam int HAND_LEFT_BIT     = 2;
  localparam int HAND_RIGHT_BIT    = 3;
  localparam int COLLECT_LEFT_BIT  = 4;
  localparam int COLLECT_RIGHT_BIT = 5;

  localparam logic [7:0] ARMS_M    = (8'd1 << ARM_LEFT_BIT) | (8'd1 << ARM_RIGHT_BIT);
  localparam logic [7:0] HANDS_M   = (8'd1 << HAND_LEFT_BIT) | (8'd1 << HAND_RIGHT_BIT);
  localparam logic [7:0] COLL_L_M  = 8'd1 << COLLECT_LEFT_BIT;
  localparam logic [7:0] COLL_R_M  = 8'd1 << COLLECT_RIGHT_BIT;
  localparam logic [7:0] COLL_M    = COLL_L_M | COLL_R_M;

  localparam int MS_W = 10;
  localparam logic [MS_W-1:0] MS_MAX     = '1;
  localparam logic [MS_W-1:0] WAIT_600   = MS_W'(600);
  localparam logic [MS_W-1:0] WAIT_100   = MS_W'(100);
  localparam logic [MS_W-1:0] WAIT_1000  = MS_W'(1000);
  localparam logic [MS_W-1:0] WAIT_500   = MS_W'(500);

  typedef struct packed {
    action_t    action;
    logic [2:0] process_id;
    logic [7:0] out_byte;
    logic [2:0] out_port;
    logic       out_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] valve_bits;
    logic       status_lamp;
    logic       busy_res;
  } out_item_t;

endpackage

// ===== src/timed_valve_sequencer.sv =====
// Top level: timed valve sequencer, one result item per input item.
//
//  channel | direction | payload                          | handshake
//  in_     | input     | action, process_id, byte, bit op | in_valid / in_ready
//  out_    | output    | valve_bits, status_lamp, busy_res | out_valid / out_ready
//
// State updates and the result register loads on the accepting edge.
// The result appears in out_data the cycle after acceptance.
// in_ready is high whenever the result register is empty or being drained.
// Synchronous reset clears all sequence state, the valve byte and the lamp.
module timed_valve_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tvs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tvs_pkg::out_item_t out_data
);
  import tvs_pkg::*;

  logic [7:0]      staged_r, staged_nxt;
  logic [7:0]      latched_r, latched_nxt;
  logic [2:0]      step_r, step_nxt;
  logic [2:0]      seq_r, seq_nxt;
  logic            running_r, running_nxt;
  logic [MS_W-1:0] elapsed_r, elapsed_nxt;
  logic            lamp_r, lamp_nxt;
  logic            out_valid_r;
  out_item_t       out_data_r;

  logic            in_fire;
  logic [MS_W-1:0] wait_limit;
  logic [MS_W-1:0] wait_el;
  logic            wait_done;
  logic [7:0]      port_m;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign port_m    = 8'd1 << in_data.out_port;

  // wait step bookkeeping
  always_comb begin
    if (step_r == STEP_WAIT_A) begin
      if (seq_r == SEQ_CATCH) begin
        wait_limit = WAIT_600;
      end else if (seq_r == SEQ_RESET) begin
        wait_limit = WAIT_500;
      end else begin
        wait_limit = WAIT_1000;
      end
    end else begin
      wait_limit = (seq_r == SEQ_CATCH) ? WAIT_100 : WAIT_500;
    end
    if (!running_r) begin
      wait_el = '0;
    end else if (elapsed_r < MS_MAX) begin
      wait_el = elapsed_r + MS_W'(1);
    end else begin
      wait_el = elapsed_r;
    end
    wait_done = (wait_el >= wait_limit);
  end

  always_comb begin
    staged_nxt  = staged_r;
    latched_nxt = latched_r;
    step_nxt    = step_r;
    seq_nxt     = seq_r;
    running_nxt = running_r;
    elapsed_nxt = elapsed_r;
    lamp_nxt    = lamp_r;
    if (in_fire) begin
      unique case (in_data.action)
        ACT_TICK: begin
          if (step_r == STEP_FIRST) begin
            case (seq_r) inside
              SEQ_CATCH, SEQ_SHOOT_START, SEQ_RESET: begin
                staged_nxt  = staged_r | ARMS_M;
                latched_nxt = staged_nxt;
              end
              SEQ_SHOOT_STOP: begin
                staged_nxt  = staged_r & ~ARMS_M;
                latched_nxt = staged_nxt;
              end
              SEQ_RIGHT: begin
                staged_nxt  = staged_r & ~COLL_R_M;
                latched_nxt = staged_nxt;
              end
              SEQ_LEFT: begin
                staged_nxt  = staged_r & ~COLL_L_M;
                latched_nxt = staged_nxt;
              end
              default: ;
            endcase
            lamp_nxt = 1'b1;
            step_nxt = STEP_WAIT_A;
          end else if (step_r != STEP_IDLE) begin
            if (seq_r == SEQ_CATCH || seq_r == SEQ_RESET) begin
              case (step_r) inside
                STEP_WAIT_A, STEP_WAIT_B: begin
                  running_nxt = !wait_done;
                  elapsed_nxt = wait_el;
                  if (wait_done) begin
                    step_nxt = step_r + 3'd1;
                  end
                end
                STEP_MID: begin
                  lamp_nxt = 1'b0;
                  if (seq_r == SEQ_CATCH) begin
                    staged_nxt = staged_r | HANDS_M;
                  end else begin
                    staged_nxt = staged_r & ~HANDS_M;
                  end
                  latched_nxt = staged_nxt;
                  step_nxt    = STEP_WAIT_B;
                end
                STEP_LAST: begin
                  lamp_nxt    = 1'b1;
                  staged_nxt  = staged_r & ~ARMS_M;
                  latched_nxt = staged_nxt;
                  step_nxt    = STEP_END;
                end
                default: step_nxt = STEP_IDLE;
              endcase
            end else begin
              case (step_r)
                STEP_WAIT_A: begin
                  running_nxt = !wait_done;
                  elapsed_nxt = wait_el;
                  if (wait_done) begin
                    step_nxt = STEP_MID;
                  end
                end
                STEP_MID: begin
                  lamp_nxt = 1'b0;
                  if (seq_r == SEQ_SHOOT_START) begin
                    staged_nxt  = staged_r & ~HANDS_M;
                    latched_nxt = staged_nxt;
                  end else if (seq_r == SEQ_SHOOT_STOP) begin
                    // staged only, latched on the next write
                    staged_nxt = staged_r & ~(HANDS_M | COLL_M);
                  end else if (seq_r == SEQ_RIGHT) begin
                    staged_nxt  = staged_r | COLL_R_M;
                    latched_nxt = staged_nxt;
                  end else begin
                    staged_nxt  = staged_r | COLL_L_M;
                    latched_nxt = staged_nxt;
                  end
                  step_nxt = STEP_WAIT_B;
                end
                default: step_nxt = STEP_IDLE;
              endcase
            end
          end
        end
        ACT_START: begin
          if (step_r == STEP_IDLE && in_data.process_id <= SEQ_RESET) begin
            seq_nxt  = in_data.process_id;
            step_nxt = STEP_FIRST;
          end
        end
        ACT_BYTE: begin
          staged_nxt  = in_data.out_byte;
          latched_nxt = in_data.out_byte;
        end
        ACT_BIT: begin
          if (in_data.out_on) begin
            staged_nxt = staged_r | port_m;
          end else begin
            staged_nxt = staged_r & ~port_m;
          end
          latched_nxt = staged_nxt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      staged_r    <= '0;
      latched_r   <= '0;
      step_r      <= STEP_IDLE;
      seq_r       <= SEQ_CATCH;
      running_r   <= 1'b0;
      elapsed_r   <= '0;
      lamp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      staged_r  <= staged_nxt;
      latched_r <= latched_nxt;
      step_r    <= step_nxt;
      seq_r     <= seq_nxt;
      running_r <= running_nxt;
      elapsed_r <= elapsed_nxt;
      lamp_r    <= lamp_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.valve_bits  <= latched_nxt;
      out_data_r.status_lamp <= lamp_nxt;
      out_data_r.busy_res    <= (step_nxt != STEP_IDLE);
    end
  end

endmodule
